[src/mtpc_pkg.sv]
// ----------------------------------------------------------------------------
// mtpc_pkg
// Shared types, widths and helpers for the Mandelbrot tile pixel colour block.
// ----------------------------------------------------------------------------
package mtpc_pkg;

    localparam int TILE_SIZE_DEF     = 256;
    localparam int FRACTION_BITS_DEF = 58;

    localparam int COORD_W     = 64;
    localparam int HALF_W      = 32;
    localparam int INDEX_W     = 8;
    localparam int LIMIT_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int LEVEL_W     = 8;
    localparam int WIDE_W      = 128;
    localparam int PROD_W      = COORD_W + INDEX_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int CFG_INDEX_W = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2000;

    localparam logic [CFG_INDEX_W-1:0] CFG_X_START = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_START = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_END   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_END   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT   = 3'd4;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_row;
        logic [INDEX_W-1:0] pixel_column;
    } t_pixel;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [COUNT_W-1:0] escape_count;
    } t_result;

    typedef enum logic [1:0] {
        ACC_SR,
        ACC_SI,
        ACC_PR
    } t_acc_sel;

    // shift is in 32-bit words: 0, 1 or 2
    typedef struct packed {
        logic     valid;
        t_acc_sel acc;
        logic [1:0] shift;
    } t_mul_tag;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
        logic [SUM_W-COORD_W:0] hi_bits;
        hi_bits = v[SUM_W-1:COORD_W-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return v[COORD_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

[src/mtpc_mul32.sv]
// ----------------------------------------------------------------------------
// mtpc_mul32
// Shared 32x32 unsigned multiplier with registered product and request tag.
// ----------------------------------------------------------------------------
module mtpc_mul32 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [mtpc_pkg::HALF_W-1:0]    i_a,
    input  logic [mtpc_pkg::HALF_W-1:0]    i_b,
    input  mtpc_pkg::t_mul_tag             i_tag,
    output logic [2*mtpc_pkg::HALF_W-1:0]  o_p,
    output mtpc_pkg::t_mul_tag             o_tag
);
    import mtpc_pkg::*;

    logic [2*HALF_W-1:0] r_p;
    t_mul_tag            r_tag;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_p   = r_p;
    assign o_tag = r_tag;

endmodule

[src/mtpc_coord.sv]
// ----------------------------------------------------------------------------
// mtpc_coord
// Point coordinate: start + floor((end - start) * index / TILE_SIZE),
// saturated. The power-of-two division is a shift of the exact product.
// ----------------------------------------------------------------------------
module mtpc_coord #(
    parameter int TILE_SIZE = mtpc_pkg::TILE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [mtpc_pkg::COORD_W-1:0]  i_start,
    input  logic [mtpc_pkg::COORD_W-1:0]  i_end,
    input  logic [mtpc_pkg::INDEX_W-1:0]  i_index,
    output logic [mtpc_pkg::COORD_W-1:0]  o_coord,
    output logic                          o_done
);
    import mtpc_pkg::*;

    localparam int SHIFT = $clog2(TILE_SIZE);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_FIX,
        C_ADD
    } t_state;

    t_state              r_state;
    logic [COORD_W-1:0]  r_start;
    logic [COORD_W-1:0]  r_dmag;
    logic [INDEX_W-1:0]  r_idx;
    logic                r_neg;
    logic [PROD_W-1:0]   r_p;
    logic [PROD_W:0]     r_qs;
    logic [COORD_W-1:0]  r_coord;
    logic                r_done;

    logic                w_neg;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_quot;
    logic                w_exact;
    logic [SUM_W-1:0]    w_sum;

    assign w_neg   = $signed(i_end) < $signed(i_start);
    assign w_prod  = r_dmag * r_idx;
    assign w_quot  = r_p >> SHIFT;
    assign w_exact = (r_p[SHIFT-1:0] == '0);
    assign w_sum   = {{(SUM_W-COORD_W){r_start[COORD_W-1]}}, r_start}
                   + {r_qs[PROD_W], r_qs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == C_ADD);
            case (r_state)
                C_IDLE: begin
                    if (i_go) begin
                        r_start <= i_start;
                        r_idx   <= i_index;
                        r_neg   <= w_neg;
                        r_dmag  <= w_neg ? (i_start - i_end) : (i_end - i_start);
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_p     <= w_prod;
                    r_state <= C_FIX;
                end
                C_FIX: begin
                    // -(q + (rem != 0)) == ~q + (rem == 0)
                    r_qs <= r_neg ? (~{1'b0, w_quot} + (PROD_W+1)'(w_exact))
                                  : {1'b0, w_quot};
                    r_state <= C_ADD;
                end
                C_ADD: begin
                    r_coord <= sat_coord(w_sum);
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_coord = r_coord;
    assign o_done  = r_done;

endmodule

[src/mtpc_colour.sv]
// ----------------------------------------------------------------------------
// mtpc_colour
// Maps an escape count to RGB through six bands. Three-stage pipeline;
// constant division by reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module mtpc_colour (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [mtpc_pkg::COUNT_W-1:0]  i_count,
    input  logic                          i_escaped,
    output logic                          o_done,
    output mtpc_pkg::t_result             o_result
);
    import mtpc_pkg::*;

    localparam int M_W      = COUNT_W + LEVEL_W;
    localparam int RECIP_W  = 26;
    localparam int MP_W     = M_W + RECIP_W;
    localparam int DIV_SH   = 32;
    localparam int Q_W      = MP_W - DIV_SH;
    localparam int D_W      = 9;
    localparam int R_W      = Q_W + D_W;

    localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949672;
    localparam logic [RECIP_W-1:0] RECIP_500 = 26'd8589934;
    localparam logic [D_W-1:0]     DIV_100   = 9'd100;
    localparam logic [D_W-1:0]     DIV_500   = 9'd500;

    localparam logic [COUNT_W-1:0] BAND_1 = 17'd100;
    localparam logic [COUNT_W-1:0] BAND_2 = 17'd200;
    localparam logic [COUNT_W-1:0] BAND_3 = 17'd300;
    localparam logic [COUNT_W-1:0] BAND_4 = 17'd400;
    localparam logic [COUNT_W-1:0] BAND_5 = 17'd500;

    typedef enum logic [2:0] {
        B_RED,
        B_GREEN,
        B_BLUE,
        B_MAGENTA,
        B_CYAN,
        B_GRAY,
        B_BLACK
    } t_band;

    logic               r_v1, r_v2, r_done;
    t_band              r_band1, r_band2;
    logic [COUNT_W-1:0] r_count1, r_count2;
    logic [M_W-1:0]     r_m1, r_m2;
    logic [MP_W-1:0]    r_prod2;
    t_result            r_result;

    t_band              w_band;
    logic [COUNT_W-1:0] w_base;
    logic [COUNT_W-1:0] w_x;
    logic [M_W-1:0]     w_m;
    logic [RECIP_W-1:0] w_recip;
    logic [D_W-1:0]     w_div;
    logic [Q_W-1:0]     w_qest;
    logic [R_W-1:0]     w_qd;
    logic [R_W-1:0]     w_rem;
    logic [Q_W-1:0]     w_q;
    logic [LEVEL_W-1:0] w_level;
    t_result            w_result;

    always_comb begin
        if (!i_escaped) begin
            w_band = B_BLACK;
            w_base = i_count;
        end else if (i_count < BAND_1) begin
            w_band = B_RED;
            w_base = '0;
        end else if (i_count < BAND_2) begin
            w_band = B_GREEN;
            w_base = BAND_1;
        end else if (i_count < BAND_3) begin
            w_band = B_BLUE;
            w_base = BAND_2;
        end else if (i_count < BAND_4) begin
            w_band = B_MAGENTA;
            w_base = BAND_3;
        end else if (i_count < BAND_5) begin
            w_band = B_CYAN;
            w_base = BAND_4;
        end else begin
            w_band = B_GRAY;
            w_base = BAND_5;
        end
    end

    assign w_x     = i_count - w_base;
    assign w_m     = {w_x, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, w_x};
    assign w_recip = (r_band1 == B_GRAY) ? RECIP_500 : RECIP_100;
    assign w_div   = (r_band2 == B_GRAY) ? DIV_500 : DIV_100;
    assign w_qest  = r_prod2[MP_W-1:DIV_SH];
    assign w_qd    = R_W'(w_qest) * R_W'(w_div);
    assign w_rem   = R_W'(r_m2) - w_qd;
    assign w_q     = (w_rem >= R_W'(w_div)) ? (w_qest + 1'b1) : w_qest;
    assign w_level = w_q[LEVEL_W-1:0];

    always_comb begin
        w_result              = '0;
        w_result.escape_count = r_count2;
        case (r_band2)
            B_RED:     w_result.red = w_level;
            B_GREEN:   w_result.green = w_level;
            B_BLUE:    w_result.blue = w_level;
            B_MAGENTA: begin
                w_result.red  = w_level;
                w_result.blue = w_level;
            end
            B_CYAN: begin
                w_result.green = w_level;
                w_result.blue  = w_level;
            end
            B_GRAY: begin
                w_result.red   = w_level;
                w_result.green = w_level;
                w_result.blue  = w_level;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_band1  <= w_band;
        r_count1 <= i_count;
        r_m1     <= w_m;
        r_band2  <= r_band1;
        r_count2 <= r_count1;
        r_m2     <= r_m1;
        r_prod2  <= r_m1 * w_recip;
        if (r_v2) begin
            r_result <= w_result;
        end
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_go;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[src/mandelbrot_tile_pixel_colour.sv]
// ----------------------------------------------------------------------------
// mandelbrot_tile_pixel_colour
// Escape-time colour of one tile pixel; z = z*z + c on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Steps: setup (coordinate product, shift, add); per iteration prep, 12 partial
// products on the shared multiplier, drain, test, update; a final test; then
// colour mapping. Result strobe o_done lasts one cycle; no receiver stall.
// A new request is taken once the block is idle again after the result strobe.
// Synchronous active-low reset: idle, tile bounds 0, iteration limit 2000.
module mandelbrot_tile_pixel_colour #(
    parameter int TILE_SIZE     = mtpc_pkg::TILE_SIZE_DEF,
    parameter int FRACTION_BITS = mtpc_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mtpc_pkg::t_pixel                  i_pixel,
    output logic                              o_done,
    output mtpc_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [mtpc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mtpc_pkg::COORD_W-1:0]      i_cfg_data
);
    import mtpc_pkg::*;

    localparam logic [WIDE_W-1:0] FOUR = {{(WIDE_W-1){1'b0}}, 1'b1} << (2 + 2*FRACTION_BITS);
    localparam logic [3:0]        K_LAST = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD,
        S_PREP,
        S_MUL,
        S_DRAIN,
        S_CHECK,
        S_UPD,
        S_COLOUR
    } t_state;

    function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    t_state              r_state;
    logic [COORD_W-1:0]  r_x_start, r_y_start, r_x_end, r_y_end;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_coord_go;
    logic [INDEX_W-1:0]  r_row, r_col;
    logic [COORD_W-1:0]  r_cr, r_ci, r_zr, r_zi, r_mr, r_mi;
    logic                r_neg;
    logic [3:0]          r_k;
    logic [WIDE_W-1:0]   r_sr, r_si, r_pr, r_diff, r_prs;
    logic [COUNT_W-1:0]  r_n;
    logic                r_escaped;
    logic                r_col_go;

    logic [COORD_W-1:0]  w_x_coord, w_y_coord;
    logic                w_x_done, w_y_done;
    logic [COORD_W-1:0]  w_op_a, w_op_b;
    logic [HALF_W-1:0]   w_half_a, w_half_b;
    t_mul_tag            w_tag_in, w_tag_out;
    logic [2*HALF_W-1:0] w_prod;
    logic [WIDE_W-1:0]   w_term;
    logic [COORD_W-1:0]  w_z2r, w_z2i;
    logic [SUM_W-1:0]    w_zr_sum, w_zi_sum;
    logic                w_over, w_esc;
    logic                w_col_done;
    t_result             w_col_result;

    mtpc_coord #(.TILE_SIZE(TILE_SIZE)) u_coord_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_coord_go),
        .i_start (r_x_start),
        .i_end   (r_x_end),
        .i_index (r_col),
        .o_coord (w_x_coord),
        .o_done  (w_x_done)
    );

    mtpc_coord #(.TILE_SIZE(TILE_SIZE)) u_coord_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_coord_go),
        .i_start (r_y_start),
        .i_end   (r_y_end),
        .i_index (r_row),
        .o_coord (w_y_coord),
        .o_done  (w_y_done)
    );

    // operand schedule: k[3:2] picks the square/product, k[1:0] the halves
    always_comb begin
        w_op_a   = (r_k[3:2] == 2'd1) ? r_mi : r_mr;
        w_op_b   = (r_k[3:2] == 2'd0) ? r_mr : r_mi;
        w_half_a = r_k[1] ? w_op_a[COORD_W-1:HALF_W] : w_op_a[HALF_W-1:0];
        w_half_b = r_k[0] ? w_op_b[COORD_W-1:HALF_W] : w_op_b[HALF_W-1:0];
        w_tag_in.valid = (r_state == S_MUL);
        w_tag_in.shift = {1'b0, r_k[1]} + {1'b0, r_k[0]};
        case (r_k[3:2])
            2'd0:    w_tag_in.acc = ACC_SR;
            2'd1:    w_tag_in.acc = ACC_SI;
            default: w_tag_in.acc = ACC_PR;
        endcase
    end

    mtpc_mul32 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (w_half_a),
        .i_b     (w_half_b),
        .i_tag   (w_tag_in),
        .o_p     (w_prod),
        .o_tag   (w_tag_out)
    );

    always_comb begin
        case (w_tag_out.shift)
            2'd0:    w_term = {{(2*HALF_W){1'b0}}, w_prod};
            2'd1:    w_term = {{HALF_W{1'b0}}, w_prod, {HALF_W{1'b0}}};
            2'd2:    w_term = {w_prod, {(2*HALF_W){1'b0}}};
            default: w_term = '0;
        endcase
    end

    assign w_z2r    = r_diff[FRACTION_BITS +: COORD_W];
    assign w_z2i    = r_prs[FRACTION_BITS-1 +: COORD_W];
    assign w_zr_sum = {{(SUM_W-COORD_W){w_z2r[COORD_W-1]}}, w_z2r}
                    + {{(SUM_W-COORD_W){r_cr[COORD_W-1]}}, r_cr};
    assign w_zi_sum = {{(SUM_W-COORD_W){w_z2i[COORD_W-1]}}, w_z2i}
                    + {{(SUM_W-COORD_W){r_ci[COORD_W-1]}}, r_ci};
    assign w_over   = r_n > {1'b0, r_limit};
    assign w_esc    = (r_sr + r_si) > FOUR;

    mtpc_colour u_colour (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_col_go),
        .i_count   (r_n),
        .i_escaped (r_escaped),
        .o_done    (w_col_done),
        .o_result  (w_col_result)
    );

    always_ff @(posedge i_clk) begin
        if (w_tag_out.valid) begin
            case (w_tag_out.acc)
                ACC_SR:  r_sr <= r_sr + w_term;
                ACC_SI:  r_si <= r_si + w_term;
                ACC_PR:  r_pr <= r_pr + w_term;
                default: begin
                end
            endcase
        end
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_x_start  <= '0;
            r_y_start  <= '0;
            r_x_end    <= '0;
            r_y_end    <= '0;
            r_limit    <= LIMIT_RESET;
            r_coord_go <= 1'b0;
            r_col_go   <= 1'b0;
        end else begin
            r_coord_go <= (r_state == S_IDLE) && start;
            r_col_go   <= (r_state == S_CHECK) && (w_over || w_esc);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_X_START: r_x_start <= i_cfg_data;
                    CFG_Y_START: r_y_start <= i_cfg_data;
                    CFG_X_END:   r_x_end   <= i_cfg_data;
                    CFG_Y_END:   r_y_end   <= i_cfg_data;
                    CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_row      <= i_pixel.pixel_row;
                        r_col      <= i_pixel.pixel_column;
                        r_zr       <= '0;
                        r_zi       <= '0;
                        r_n        <= '0;
                        r_state    <= S_COORD;
                    end
                end
                S_COORD: begin
                    if (w_x_done) begin
                        r_cr    <= w_x_coord;
                        r_ci    <= w_y_coord;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_mr    <= mag(r_zr);
                    r_mi    <= mag(r_zi);
                    r_neg   <= r_zr[COORD_W-1] ^ r_zi[COORD_W-1];
                    r_sr    <= '0;
                    r_si    <= '0;
                    r_pr    <= '0;
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_over) begin
                        r_escaped <= 1'b0;
                        r_state   <= S_COLOUR;
                    end else if (w_esc) begin
                        r_escaped <= 1'b1;
                        r_state   <= S_COLOUR;
                    end else begin
                        r_diff  <= r_sr - r_si;
                        r_prs   <= r_neg ? (~r_pr + 1'b1) : r_pr;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_zr    <= sat_coord(w_zr_sum);
                    r_zi    <= sat_coord(w_zi_sum);
                    r_n     <= r_n + 1'b1;
                    r_state <= S_PREP;
                end
                S_COLOUR: begin
                    if (w_col_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = w_col_done;
    assign o_result = w_col_result;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_done_in_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_COLOUR))
        else $error("result strobe outside colour phase");

    a_mul_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag_out.valid |-> (r_state == S_MUL || r_state == S_DRAIN))
        else $error("partial product outside multiply window");

    a_coord_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_x_done == w_y_done)
        else $error("coordinate units out of step");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.escape_count <= ({1'b0, r_limit} + 1'b1)))
        else $error("escape count beyond limit plus one");

endmodule
